[rtl/core/uart_tf_pkg.sv]
// Package for the 8N1 UART transceiver with ring FIFOs.
// Holds the channel word types, state encodings and fixed constants.
// No dependencies.
`timescale 1ns / 1ps

package uart_tf_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEVEL_W = 5;
    localparam int BIT_W   = 3;

    localparam logic [BYTE_W-1:0] BIT_TICKS_RESET = 8'd104;
    localparam logic [BIT_W-1:0]  LAST_BIT        = 3'd7;

    // one tick from the baud timer with the fifo requests
    typedef struct packed {
        logic              rx_line;
        logic              tx_push;
        logic [BYTE_W-1:0] tx_byte;
        logic              rx_pop;
    } in_word_t;

    // line levels and fifo status after one tick
    typedef struct packed {
        logic               tx_line;
        logic               tx_accepted;
        logic [BYTE_W-1:0]  rx_byte;
        logic               rx_byte_valid;
        logic [LEVEL_W-1:0] rx_level;
        logic               tx_busy;
    } out_word_t;

    typedef enum logic [1:0] {
        TX_IDLE,
        TX_START,
        TX_DATA,
        TX_STOP
    } tx_state_t;

    typedef enum logic [2:0] {
        RX_IDLE,
        RX_START,
        RX_HALF,
        RX_DATA,
        RX_STOP
    } rx_state_t;

endpackage

[rtl/core/uart_tf_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module uart_tf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read, old data on a collision
    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/uart_8n1_transceiver_fifo.sv]
// 8N1 UART transceiver stepped by baud ticks, with transmit and receive ring FIFOs.
// Depends on uart_tf_pkg and uart_tf_ram.
// Result words are registered; the FIFO heads are prefetched from RAM every cycle.
// Throughput: one tick per cycle, while no result word waits with m_ready low.
// Reset (aresetn low, synchronous): both machines idle, both FIFOs empty, line seen
// idle high, bit_ticks back to 104, no result word pending.
`timescale 1ns / 1ps

module uart_8n1_transceiver_fifo
    import uart_tf_pkg::*;
#(
    parameter int TX_DEPTH = 16,
    parameter int RX_DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [BYTE_W-1:0] cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_word_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_word_t         m_data
);

    localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int TX_FW = $clog2(TX_DEPTH + 1);
    localparam int TX_SW = TX_AW + 1;
    localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int RX_FW = $clog2(RX_DEPTH + 1);
    localparam int RX_SW = RX_AW + 1;

    logic s_fire;

    logic [BYTE_W-1:0] bit_ticks_reg;
    logic [BYTE_W-1:0] lim;
    logic [BYTE_W-1:0] half;

    // transmit state
    tx_state_t         tx_state_reg, tx_state_next;
    logic [BYTE_W-1:0] tx_shift_reg, tx_shift_next;
    logic [BYTE_W-1:0] tx_count_reg, tx_count_next;
    logic [BIT_W-1:0]  tx_bit_reg, tx_bit_next;
    logic [TX_AW-1:0]  tx_head_reg, tx_head_next;
    logic [TX_FW-1:0]  tx_fill_reg, tx_fill_next;
    logic              tx_byp_hit_reg;
    logic [BYTE_W-1:0] tx_byp_data_reg;
    logic              tx_push_ok;
    logic [TX_FW-1:0]  tx_fill_push;
    logic              tx_pop;
    logic [BYTE_W-1:0] tx_pop_byte;
    logic [BYTE_W-1:0] tx_head_data;
    logic [BYTE_W-1:0] tx_rdata;
    logic [BYTE_W-1:0] tx_count_inc;
    logic              tx_done;
    logic [TX_SW-1:0]  tx_tail_sum;
    logic [TX_AW-1:0]  tx_waddr;
    logic [TX_AW-1:0]  tx_raddr;
    logic              tx_we;

    // receive state
    rx_state_t         rx_state_reg, rx_state_next;
    logic [BYTE_W-1:0] rx_shift_reg, rx_shift_next;
    logic [BYTE_W-1:0] rx_count_reg, rx_count_next;
    logic [BIT_W-1:0]  rx_bit_reg, rx_bit_next;
    logic              rx_prev_reg;
    logic [RX_AW-1:0]  rx_head_reg, rx_head_next;
    logic [RX_FW-1:0]  rx_fill_reg, rx_fill_next;
    logic              rx_byp_hit_reg;
    logic [BYTE_W-1:0] rx_byp_data_reg;
    logic              rx_pop_ok;
    logic [RX_FW-1:0]  rx_fill_pop;
    logic              rx_store;
    logic [BYTE_W-1:0] rx_head_data;
    logic [BYTE_W-1:0] rx_rdata;
    logic [BYTE_W-1:0] rx_lim;
    logic [BYTE_W-1:0] rx_count_inc;
    logic              rx_done;
    logic [RX_SW-1:0]  rx_tail_sum;
    logic [RX_AW-1:0]  rx_waddr;
    logic [RX_AW-1:0]  rx_raddr;
    logic              rx_we;

    // result register
    logic      m_valid_reg;
    out_word_t m_data_reg;
    out_word_t out_next;

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // bit period limits, zero acts as one
    assign lim  = (bit_ticks_reg == '0) ? 8'd1 : bit_ticks_reg;
    assign half = (bit_ticks_reg[BYTE_W-1:1] == '0) ? 8'd1 : {1'b0, bit_ticks_reg[BYTE_W-1:1]};

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_ticks_reg <= BIT_TICKS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            bit_ticks_reg <= cfg_data;
        end
    end

    // ---------------- transmit ----------------

    // push into the transmit fifo
    assign tx_push_ok   = s_data.tx_push && (tx_fill_reg < TX_FW'(TX_DEPTH));
    assign tx_fill_push = tx_fill_reg + TX_FW'(tx_push_ok);
    assign tx_tail_sum  = {1'b0, tx_head_reg} + TX_SW'(tx_fill_reg);
    assign tx_waddr     = (tx_tail_sum >= TX_SW'(TX_DEPTH))
                        ? TX_AW'(tx_tail_sum - TX_SW'(TX_DEPTH)) : TX_AW'(tx_tail_sum);
    assign tx_we        = s_fire && tx_push_ok;

    // head word: prefetched entry, or the byte pushed into an empty queue
    assign tx_head_data = tx_byp_hit_reg ? tx_byp_data_reg : tx_rdata;
    assign tx_pop_byte  = (tx_fill_reg == '0) ? s_data.tx_byte : tx_head_data;

    // bit timer
    assign tx_count_inc = tx_count_reg + 8'd1;
    assign tx_done      = (tx_count_inc >= lim);

    // transmit next state
    always_comb begin
        tx_state_next = tx_state_reg;
        tx_shift_next = tx_shift_reg;
        tx_count_next = tx_count_reg;
        tx_bit_next   = tx_bit_reg;
        tx_pop        = 1'b0;
        case (tx_state_reg)
            TX_IDLE: begin
                if (tx_fill_push != '0) begin
                    tx_pop        = 1'b1;
                    tx_shift_next = tx_pop_byte;
                    tx_state_next = TX_START;
                    tx_count_next = '0;
                end
            end
            default: begin
                tx_count_next = tx_done ? '0 : tx_count_inc;
                if (tx_done) begin
                    case (tx_state_reg)
                        TX_START: begin
                            tx_state_next = TX_DATA;
                            tx_bit_next   = '0;
                        end
                        TX_DATA: begin
                            tx_shift_next = {1'b0, tx_shift_reg[BYTE_W-1:1]};
                            if (tx_bit_reg == LAST_BIT) begin
                                tx_state_next = TX_STOP;
                            end else begin
                                tx_bit_next = tx_bit_reg + 3'd1;
                            end
                        end
                        TX_STOP: begin
                            if (tx_fill_push != '0) begin
                                tx_pop        = 1'b1;
                                tx_shift_next = tx_pop_byte;
                                tx_state_next = TX_START;
                            end else begin
                                tx_state_next = TX_IDLE;
                            end
                        end
                        default: begin
                            tx_state_next = TX_IDLE;
                        end
                    endcase
                end
            end
        endcase
    end

    // transmit fifo pointers
    assign tx_fill_next = tx_fill_push - TX_FW'(tx_pop);
    assign tx_head_next = !tx_pop ? tx_head_reg
                        : (tx_head_reg == TX_AW'(TX_DEPTH - 1)) ? '0
                        : tx_head_reg + TX_AW'(1);
    assign tx_raddr     = !aresetn ? '0 : (s_fire ? tx_head_next : tx_head_reg);

    uart_tf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TX_DEPTH),
        .AW    (TX_AW)
    ) u_tx_ram (
        .aclk  (aclk),
        .we    (tx_we),
        .waddr (tx_waddr),
        .wdata (s_data.tx_byte),
        .raddr (tx_raddr),
        .rdata (tx_rdata)
    );

    // transmit registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_state_reg   <= TX_IDLE;
            tx_shift_reg   <= '0;
            tx_count_reg   <= '0;
            tx_bit_reg     <= '0;
            tx_head_reg    <= '0;
            tx_fill_reg    <= '0;
            tx_byp_hit_reg <= 1'b0;
        end else begin
            tx_byp_hit_reg <= tx_we && (tx_waddr == tx_raddr);
            if (s_fire) begin
                tx_state_reg <= tx_state_next;
                tx_shift_reg <= tx_shift_next;
                tx_count_reg <= tx_count_next;
                tx_bit_reg   <= tx_bit_next;
                tx_head_reg  <= tx_head_next;
                tx_fill_reg  <= tx_fill_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        tx_byp_data_reg <= s_data.tx_byte;
    end

    // ---------------- receive ----------------

    // pop from the receive fifo
    assign rx_pop_ok    = s_data.rx_pop && (rx_fill_reg != '0);
    assign rx_fill_pop  = rx_fill_reg - RX_FW'(rx_pop_ok);
    assign rx_head_next = !rx_pop_ok ? rx_head_reg
                        : (rx_head_reg == RX_AW'(RX_DEPTH - 1)) ? '0
                        : rx_head_reg + RX_AW'(1);
    assign rx_head_data = rx_byp_hit_reg ? rx_byp_data_reg : rx_rdata;

    // bit timer, half period while centering on the start bit
    assign rx_lim       = (rx_state_reg == RX_HALF) ? half : lim;
    assign rx_count_inc = rx_count_reg + 8'd1;
    assign rx_done      = (rx_count_inc >= rx_lim);

    // receive next state
    always_comb begin
        rx_state_next = rx_state_reg;
        rx_shift_next = rx_shift_reg;
        rx_count_next = rx_count_reg;
        rx_bit_next   = rx_bit_reg;
        rx_store      = 1'b0;
        case (rx_state_reg)
            RX_IDLE: begin
                if (rx_prev_reg && !s_data.rx_line) begin
                    rx_state_next = RX_START;
                    rx_count_next = '0;
                end
            end
            default: begin
                rx_count_next = rx_done ? '0 : rx_count_inc;
                if (rx_done) begin
                    case (rx_state_reg)
                        RX_START: begin
                            rx_state_next = RX_HALF;
                        end
                        RX_HALF: begin
                            rx_shift_next = {s_data.rx_line, rx_shift_reg[BYTE_W-1:1]};
                            rx_state_next = RX_DATA;
                            rx_bit_next   = 3'd1;
                        end
                        RX_DATA: begin
                            rx_shift_next = {s_data.rx_line, rx_shift_reg[BYTE_W-1:1]};
                            if (rx_bit_reg == LAST_BIT) begin
                                rx_state_next = RX_STOP;
                            end else begin
                                rx_bit_next = rx_bit_reg + 3'd1;
                            end
                        end
                        RX_STOP: begin
                            rx_store      = s_data.rx_line && (rx_fill_pop < RX_FW'(RX_DEPTH));
                            rx_state_next = RX_IDLE;
                        end
                        default: begin
                            rx_state_next = RX_IDLE;
                        end
                    endcase
                end
            end
        endcase
    end

    // receive fifo write side
    assign rx_fill_next = rx_fill_pop + RX_FW'(rx_store);
    assign rx_tail_sum  = {1'b0, rx_head_next} + RX_SW'(rx_fill_pop);
    assign rx_waddr     = (rx_tail_sum >= RX_SW'(RX_DEPTH))
                        ? RX_AW'(rx_tail_sum - RX_SW'(RX_DEPTH)) : RX_AW'(rx_tail_sum);
    assign rx_we        = s_fire && rx_store;
    assign rx_raddr     = !aresetn ? '0 : (s_fire ? rx_head_next : rx_head_reg);

    uart_tf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RX_DEPTH),
        .AW    (RX_AW)
    ) u_rx_ram (
        .aclk  (aclk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (rx_shift_reg),
        .raddr (rx_raddr),
        .rdata (rx_rdata)
    );

    // receive registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_state_reg   <= RX_IDLE;
            rx_shift_reg   <= '0;
            rx_count_reg   <= '0;
            rx_bit_reg     <= '0;
            rx_prev_reg    <= 1'b1;
            rx_head_reg    <= '0;
            rx_fill_reg    <= '0;
            rx_byp_hit_reg <= 1'b0;
        end else begin
            rx_byp_hit_reg <= rx_we && (rx_waddr == rx_raddr);
            if (s_fire) begin
                rx_state_reg <= rx_state_next;
                rx_shift_reg <= rx_shift_next;
                rx_count_reg <= rx_count_next;
                rx_bit_reg   <= rx_bit_next;
                rx_prev_reg  <= s_data.rx_line;
                rx_head_reg  <= rx_head_next;
                rx_fill_reg  <= rx_fill_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rx_byp_data_reg <= rx_shift_reg;
    end

    // ---------------- result word ----------------

    // outputs from the updated state
    always_comb begin
        case (tx_state_next)
            TX_START: out_next.tx_line = 1'b0;
            TX_DATA:  out_next.tx_line = tx_shift_next[0];
            default:  out_next.tx_line = 1'b1;
        endcase
        out_next.tx_accepted   = tx_push_ok;
        out_next.rx_byte       = rx_pop_ok ? rx_head_data : '0;
        out_next.rx_byte_valid = rx_pop_ok;
        out_next.rx_level      = LEVEL_W'(rx_fill_next);
        out_next.tx_busy       = (tx_state_next != TX_IDLE) || (tx_fill_next != '0);
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= out_next;
        end
    end

endmodule

[rtl/core/uart_tf_checker.sv]
// Port-level checks on the UART transceiver result channel, bound to the top level.
// Depends on uart_tf_pkg and uart_8n1_transceiver_fifo.
`timescale 1ns / 1ps

module uart_tf_checker
    import uart_tf_pkg::*;
#(
    parameter int RX_DEPTH = 16
) (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // no pending word right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word pending after reset");

    // an unsuccessful pop returns zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.rx_byte_valid |-> m_data.rx_byte == '0)
        else $error("rx byte nonzero without a pop");

    // receive level never exceeds the fifo depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.rx_level <= LEVEL_W'(RX_DEPTH))
        else $error("rx level above fifo depth");

    // a low transmit line only happens inside a frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.tx_line |-> m_data.tx_busy)
        else $error("tx line low while transmitter idle");

endmodule

bind uart_8n1_transceiver_fifo uart_tf_checker #(
    .RX_DEPTH (RX_DEPTH)
) u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[sim/tb_uart_8n1_transceiver_fifo.sv]
// Self-checking bench for the 8N1 UART transceiver with ring FIFOs: a tick-level
// model predicts the status word for every accepted tick and compares it field by field.
// Depends on uart_tf_pkg and the uart_8n1_transceiver_fifo RTL.
`timescale 1ns / 1ps

module tb_uart_8n1_transceiver_fifo;
    import uart_tf_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_LEN   = 7;
    localparam int TX_DEPTH    = 16;
    localparam int RX_DEPTH    = 16;
    localparam int QUIET_LIMIT = 2000;
    localparam int SHOW_LIMIT  = 10;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [BYTE_W-1:0] cfg_data  = '0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    in_word_t          s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    out_word_t         m_data;

    // idle rates of the tick source and the status sink, in percent
    int snd_idle_pct = 35;
    int rcv_idle_pct = 88;

    int        mismatch_count = 0;
    int        quiet_cycles   = 0;
    out_word_t status_due[$];
    out_word_t want_word;
    logic      line_wave[$];

    // model state
    logic [BYTE_W-1:0]  ticks_per_bit;
    tx_state_t          tx_state;
    logic [BIT_W-1:0]   tx_bit_idx;
    logic [BYTE_W-1:0]  tx_shreg;
    logic [BYTE_W-1:0]  tx_ticks;
    logic [BYTE_W-1:0]  tx_mem [TX_DEPTH];
    int unsigned        tx_rd_ptr;
    logic [LEVEL_W-1:0] tx_count;
    rx_state_t          rx_state;
    logic [BIT_W-1:0]   rx_bit_idx;
    logic [BYTE_W-1:0]  rx_shreg;
    logic [BYTE_W-1:0]  rx_ticks;
    logic               rx_line_prev;
    logic [BYTE_W-1:0]  rx_mem [RX_DEPTH];
    int unsigned        rx_rd_ptr;
    logic [LEVEL_W-1:0] rx_count;

    uart_8n1_transceiver_fifo #(
        .TX_DEPTH(TX_DEPTH),
        .RX_DEPTH(RX_DEPTH)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // status sink stalls at random
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    function automatic void clear_uart_model();
        ticks_per_bit = BIT_TICKS_RESET;
        tx_state      = TX_IDLE;
        tx_bit_idx    = '0;
        tx_shreg      = '0;
        tx_ticks      = '0;
        tx_rd_ptr     = 0;
        tx_count      = '0;
        rx_state      = RX_IDLE;
        rx_bit_idx    = '0;
        rx_shreg      = '0;
        rx_ticks      = '0;
        rx_line_prev  = 1'b1;
        rx_rd_ptr     = 0;
        rx_count      = '0;
    endfunction

    // next queued byte into the shifter, start bit begins
    function automatic void take_tx_byte();
        tx_shreg  = tx_mem[tx_rd_ptr];
        tx_rd_ptr = (tx_rd_ptr + 1) % TX_DEPTH;
        tx_count  = tx_count - LEVEL_W'(1);
        tx_state  = TX_START;
        tx_ticks  = '0;
    endfunction

    // one baud tick: push, transmit timing, pop, receive timing, edge detect
    function automatic out_word_t uart_tick(in_word_t w);
        out_word_t         res;
        logic [BYTE_W-1:0] lim;
        logic [BYTE_W-1:0] half;
        logic              rx_was_idle;
        res         = '0;
        lim         = (ticks_per_bit == '0) ? 8'd1 : ticks_per_bit;
        half        = ((ticks_per_bit >> 1) == '0) ? 8'd1 : (ticks_per_bit >> 1);
        rx_was_idle = (rx_state == RX_IDLE);

        // push, refused when the queue is full
        if (w.tx_push && tx_count < TX_DEPTH) begin
            tx_mem[(tx_rd_ptr + tx_count) % TX_DEPTH] = w.tx_byte;
            tx_count        = tx_count + LEVEL_W'(1);
            res.tx_accepted = 1'b1;
        end

        // transmit bit timing
        if (tx_state == TX_IDLE) begin
            if (tx_count > 0)
                take_tx_byte();
        end else begin
            tx_ticks = tx_ticks + 8'd1;
            if (tx_ticks >= lim) begin
                tx_ticks = '0;
                case (tx_state)
                    TX_START: begin
                        tx_state   = TX_DATA;
                        tx_bit_idx = '0;
                    end
                    TX_DATA: begin
                        tx_shreg = tx_shreg >> 1;
                        if (tx_bit_idx == LAST_BIT)
                            tx_state = TX_STOP;
                        else
                            tx_bit_idx = tx_bit_idx + 3'd1;
                    end
                    default: begin
                        if (tx_count > 0)
                            take_tx_byte();
                        else
                            tx_state = TX_IDLE;
                    end
                endcase
            end
        end
        if (tx_state == TX_START)
            res.tx_line = 1'b0;
        else if (tx_state == TX_DATA)
            res.tx_line = tx_shreg[0];
        else
            res.tx_line = 1'b1;

        // pop, nothing returned when empty
        if (w.rx_pop && rx_count > 0) begin
            res.rx_byte       = rx_mem[rx_rd_ptr];
            res.rx_byte_valid = 1'b1;
            rx_rd_ptr         = (rx_rd_ptr + 1) % RX_DEPTH;
            rx_count          = rx_count - LEVEL_W'(1);
        end

        // receive timing; bit 0 is taken when the half period ends
        if (!rx_was_idle) begin
            rx_ticks = rx_ticks + 8'd1;
            if (rx_ticks >= ((rx_state == RX_HALF) ? half : lim)) begin
                rx_ticks = '0;
                case (rx_state)
                    RX_START: rx_state = RX_HALF;
                    RX_HALF: begin
                        rx_shreg   = {w.rx_line, rx_shreg[BYTE_W-1:1]};
                        rx_bit_idx = 3'd1;
                        rx_state   = RX_DATA;
                    end
                    RX_DATA: begin
                        rx_shreg = {w.rx_line, rx_shreg[BYTE_W-1:1]};
                        if (rx_bit_idx == LAST_BIT)
                            rx_state = RX_STOP;
                        else
                            rx_bit_idx = rx_bit_idx + 3'd1;
                    end
                    default: begin
                        // good stop bit and room left: keep the byte
                        if (w.rx_line && rx_count < RX_DEPTH) begin
                            rx_mem[(rx_rd_ptr + rx_count) % RX_DEPTH] = rx_shreg;
                            rx_count = rx_count + LEVEL_W'(1);
                        end
                        rx_state = RX_IDLE;
                    end
                endcase
            end
        end else if (rx_line_prev && !w.rx_line) begin
            rx_state = RX_START;
            rx_ticks = '0;
        end
        rx_line_prev = w.rx_line;

        res.rx_level = rx_count;
        res.tx_busy  = (tx_state != TX_IDLE) || (tx_count > 0);
        return res;
    endfunction

    task automatic note_mismatch(string fname, int unsigned want, int unsigned got);
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
    endtask

    // model update on accepted words, check of each status word, watchdog
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_uart_model();
            quiet_cycles = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                ticks_per_bit = cfg_data;
            if (s_valid && s_ready)
                status_due.push_back(uart_tick(s_data));
            if (m_valid && m_ready) begin
                if (status_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_LIMIT)
                        $display("%0t: status word %h with none expected", $time, m_data);
                end else begin
                    want_word = status_due.pop_front();
                    if (m_data.tx_line !== want_word.tx_line)
                        note_mismatch("tx_line", want_word.tx_line, m_data.tx_line);
                    if (m_data.tx_accepted !== want_word.tx_accepted)
                        note_mismatch("tx_accepted", want_word.tx_accepted, m_data.tx_accepted);
                    if (m_data.rx_byte !== want_word.rx_byte)
                        note_mismatch("rx_byte", want_word.rx_byte, m_data.rx_byte);
                    if (m_data.rx_byte_valid !== want_word.rx_byte_valid)
                        note_mismatch("rx_byte_valid", want_word.rx_byte_valid,
                                      m_data.rx_byte_valid);
                    if (m_data.rx_level !== want_word.rx_level)
                        note_mismatch("rx_level", want_word.rx_level, m_data.rx_level);
                    if (m_data.tx_busy !== want_word.tx_busy)
                        note_mismatch("tx_busy", want_word.tx_busy, m_data.tx_busy);
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // one tick word, with random gaps in front of it
    task automatic send_tick(in_word_t w);
        while ($urandom_range(99) < snd_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic hold_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (status_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_bit_ticks(logic [BYTE_W-1:0] value);
        hold_until_drained();
        repeat (3) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // receive line levels: mostly clean frames at the current rate, some noise
    task automatic queue_rx_frame(int noise_pct);
        int unsigned         per_bit;
        logic [9:0]          frame_bits;
        int                  k;
        per_bit = (ticks_per_bit == '0) ? 1 : ticks_per_bit;
        if ($urandom_range(99) < noise_pct) begin
            repeat ($urandom_range(1, 3 * per_bit)) line_wave.push_back(1'($urandom_range(1)));
        end else begin
            // stop, data lsb first, start; stop bit bad now and then
            frame_bits = {($urandom_range(99) >= 10), 8'($urandom), 1'b0};
            for (k = 0; k < 10; k++) begin
                repeat (per_bit) line_wave.push_back(frame_bits[k]);
            end
            repeat ($urandom_range(0, per_bit)) line_wave.push_back(1'b1);
        end
    endtask

    task automatic play_ticks(int n, int push_pct, int pop_pct, int noise_pct,
                              int pause_every);
        in_word_t w;
        int       i;
        for (i = 0; i < n; i++) begin
            if (line_wave.size() == 0)
                queue_rx_frame(noise_pct);
            w.rx_line = line_wave.pop_front();
            w.tx_push = ($urandom_range(99) < push_pct);
            w.tx_byte = 8'($urandom);
            w.rx_pop  = ($urandom_range(99) < pop_pct);
            send_tick(w);
            if (pause_every != 0 && (i % pause_every) == pause_every - 1)
                hold_until_drained();
        end
    endtask

    // pops on empty, pushes to idle and full transmitter, start edges
    task automatic test_fifo_edges();
        in_word_t w;
        int       k;
        w         = '0;
        w.rx_line = 1'b1;
        w.rx_pop  = 1'b1;
        send_tick(w);
        w.rx_pop  = 1'b0;
        w.tx_push = 1'b1;
        w.tx_byte = 8'hFF;
        send_tick(w);
        w.tx_byte = 8'h00;
        send_tick(w);
        // fill the transmit queue, last push is refused
        for (k = 0; k < 16; k++) begin
            w.tx_byte = (k < 8) ? (8'h01 << k) : 8'($urandom);
            send_tick(w);
        end
        // falling edge arms the receiver, a later one is ignored
        w.tx_push = 1'b0;
        w.rx_pop  = 1'b1;
        w.rx_line = 1'b0;
        send_tick(w);
        w.rx_line = 1'b1;
        send_tick(w);
        w.rx_line = 1'b0;
        send_tick(w);
    endtask

    // zero bit time acts as one tick, half period too; changed mid-frame
    task automatic test_tiny_bit_ticks();
        write_bit_ticks(8'd0);
        play_ticks(25, 30, 20, 10, 0);
    endtask

    // receive queue runs full and drops, transmit queue refuses
    task automatic test_rx_overflow();
        write_bit_ticks(8'd2);
        play_ticks(400, 40, 0, 0, 0);
    endtask

    task automatic test_slow_drain();
        snd_idle_pct = 88;
        rcv_idle_pct = 35;
        write_bit_ticks(8'd10);
        play_ticks(25, 5, 40, 20, 0);
    endtask

    // long bit time, sender pauses until all status words are back
    task automatic test_long_bits();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_bit_ticks(8'd254);
        play_ticks(25, 10, 10, 0, 12);
    endtask

    // short odd bit time while long frames are still in flight
    task automatic test_rate_change();
        write_bit_ticks(8'(2 * $urandom_range(1, 4) + 1));
        play_ticks(25, 20, 30, 15, 0);
    endtask

    initial begin
        repeat (RESET_LEN) @(negedge aclk);
        aresetn <= 1'b1;
        test_fifo_edges();
        test_tiny_bit_ticks();
        test_rx_overflow();
        test_slow_drain();
        test_long_bits();
        test_rate_change();
        hold_until_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && status_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
